// File: rtl/ordered_list_insert_remove_search_defines.svh
`ifndef ORDERED_LIST_INSERT_REMOVE_SEARCH_DEFINES_SVH
`define ORDERED_LIST_INSERT_REMOVE_SEARCH_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define OLIRS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define OLIRS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/olirs_pkg.sv
package olirs_pkg;

  localparam int VALUE_W = 32;
  localparam int POS_W   = 5;
  localparam int CMD_W   = 3;
  localparam int STAT_W  = 2;
  localparam int IDXO_W  = 5;

  localparam logic [CMD_W-1:0] CMD_APPEND      = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT_AT   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE_LAST = 3'd2;
  localparam logic [CMD_W-1:0] CMD_REMOVE_AT   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_REVERSE     = 3'd4;
  localparam logic [CMD_W-1:0] CMD_FIND        = 3'd5;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd3;

  localparam logic [IDXO_W-1:0] NOT_FOUND = 5'h1F;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REV,
    ST_FIND
  } olirs_state_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE,
    CELL_ROTATE,
    CELL_MATCH,
    CELL_SCAN
  } cell_op_t;

  typedef struct packed {
    cell_op_t                   op;
    logic signed [VALUE_W-1:0]  value;
  } cell_ctl_t;

endpackage

// File: rtl/olirs_cell.sv
module olirs_cell #(
  parameter int CNT_W = 5
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [CNT_W-1:0]                    cell_idx,
  input  logic [CNT_W-1:0]                    bound,
  input  logic [CNT_W-1:0]                    count,
  input  olirs_pkg::cell_ctl_t                ctl,
  input  logic signed [olirs_pkg::VALUE_W-1:0] left_entry,
  input  logic signed [olirs_pkg::VALUE_W-1:0] right_entry,
  input  logic signed [olirs_pkg::VALUE_W-1:0] head_entry,
  input  logic                                right_match,
  output logic signed [olirs_pkg::VALUE_W-1:0] entry,
  output logic                                match
);
  import olirs_pkg::*;

  logic signed [VALUE_W-1:0] entry_r;
  logic signed [VALUE_W-1:0] entry_nxt;
  logic                      match_r;
  logic                      match_nxt;

  always_comb begin
    entry_nxt = entry_r;
    match_nxt = match_r;
    case (ctl.op)
      CELL_INSERT: begin
        if (cell_idx == bound) begin
          entry_nxt = ctl.value;
        end else if (cell_idx > bound) begin
          entry_nxt = left_entry;
        end
      end
      CELL_DELETE: begin
        if (cell_idx >= bound) begin
          entry_nxt = right_entry;
        end
      end
      CELL_ROTATE: begin
        if (cell_idx < bound) begin
          entry_nxt = right_entry;
        end else if (cell_idx == bound) begin
          entry_nxt = head_entry;
        end
      end
      CELL_MATCH: begin
        match_nxt = (entry_r == ctl.value) && (cell_idx < count);
      end
      CELL_SCAN: begin
        match_nxt = right_match;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
    end else begin
      match_r <= match_nxt;
    end
  end

  assign entry = entry_r;
  assign match = match_r;

endmodule

// File: rtl/ordered_list_insert_remove_search.sv
// channel  | ports                                         | beat marked by
// ---------+-----------------------------------------------+------------------------
// command  | in_cmd, in_value, in_position                 | start high, busy low
// result   | out_status, out_found_index, out_entry_total  | out_valid, one cycle
//
// Reverse of up to one entry, find in an empty list, all else: result next cycle, no busy.
// Reverse of two or more entries: busy while it rotates, one prefix rotation per cycle.
// Find in a nonempty list: busy until a hit or the last entry is checked, flags shift one cell a cycle.
// Synchronous active-low reset clears the count, the state machine and the strobe.
// The receiver cannot stall: each result shows for exactly one cycle.
`include "ordered_list_insert_remove_search_defines.svh"

module ordered_list_insert_remove_search #(
  parameter int CAPACITY = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [olirs_pkg::CMD_W-1:0]           in_cmd,
  input  logic signed [olirs_pkg::VALUE_W-1:0]  in_value,
  input  logic [olirs_pkg::POS_W-1:0]           in_position,
  output logic                                  out_valid,
  output logic [olirs_pkg::STAT_W-1:0]          out_status,
  output logic signed [olirs_pkg::IDXO_W-1:0]   out_found_index,
  output logic [olirs_pkg::IDXO_W-1:0]          out_entry_total
);
  import olirs_pkg::*;

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;
  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);
  localparam logic [CW-1:0] ONE_CNT = CW'(1);
  localparam logic [CW-1:0] TWO_CNT = CW'(2);

  olirs_state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] lim_r, lim_nxt;
  logic [CW-1:0] idx_r, idx_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]     status_r, status_nxt;
  logic [IDXO_W-1:0]     found_r, found_nxt;
  logic [IDXO_W-1:0]     total_r, total_nxt;

  cell_ctl_t     ctl;
  logic [CW-1:0] bound;
  logic          accept;
  logic          full;
  logic          short_cmd;
  logic [CMPW-1:0] cnt_ext;
  logic [CMPW-1:0] pos_ext;
  logic [CMPW-1:0] cnt_nxt_ext;
  logic [CMPW-1:0] idx_ext;

  logic signed [VALUE_W-1:0] entry_w [CAPACITY];
  logic                      match_w [CAPACITY];

  assign busy    = (state_r != ST_IDLE);
  assign accept  = start && !busy;
  assign full    = (count_r == CAP_CNT);
  assign short_cmd = accept && (in_cmd != CMD_REVERSE) && (in_cmd != CMD_FIND);
  assign cnt_ext = CMPW'(count_r);
  assign pos_ext = CMPW'(in_position);
  assign idx_ext = CMPW'(idx_r);
  assign cnt_nxt_ext = CMPW'(count_nxt);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    lim_nxt       = lim_r;
    idx_nxt       = idx_r;
    out_valid_nxt = 1'b0;
    status_nxt    = status_r;
    found_nxt     = found_r;
    ctl.op        = CELL_HOLD;
    ctl.value     = in_value;
    bound         = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          out_valid_nxt = 1'b1;
          status_nxt    = STAT_OK;
          found_nxt     = NOT_FOUND;
          case (in_cmd)
            CMD_APPEND: begin
              if (full) begin
                status_nxt = STAT_FULL;
              end else begin
                ctl.op    = CELL_INSERT;
                bound     = count_r;
                count_nxt = count_r + ONE_CNT;
              end
            end
            CMD_INSERT_AT: begin
              if (full) begin
                status_nxt = STAT_FULL;
              end else if (pos_ext > cnt_ext) begin
                status_nxt = STAT_RANGE;
              end else begin
                ctl.op    = CELL_INSERT;
                bound     = CW'(pos_ext);
                count_nxt = count_r + ONE_CNT;
              end
            end
            CMD_REMOVE_LAST: begin
              if (count_r == '0) begin
                status_nxt = STAT_EMPTY;
              end else begin
                count_nxt = count_r - ONE_CNT;
              end
            end
            CMD_REMOVE_AT: begin
              if (count_r == '0) begin
                status_nxt = STAT_EMPTY;
              end else if (pos_ext >= cnt_ext) begin
                status_nxt = STAT_RANGE;
              end else begin
                ctl.op    = CELL_DELETE;
                bound     = CW'(pos_ext);
                count_nxt = count_r - ONE_CNT;
              end
            end
            CMD_REVERSE: begin
              if (count_r > ONE_CNT) begin
                out_valid_nxt = 1'b0;
                state_nxt     = ST_REV;
                lim_nxt       = count_r;
              end
            end
            CMD_FIND: begin
              ctl.op = CELL_MATCH;
              if (count_r != '0) begin
                out_valid_nxt = 1'b0;
                state_nxt     = ST_FIND;
                idx_nxt       = '0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_REV: begin
        ctl.op  = CELL_ROTATE;
        bound   = lim_r - ONE_CNT;
        lim_nxt = lim_r - ONE_CNT;
        if (lim_r == TWO_CNT) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          status_nxt    = STAT_OK;
          found_nxt     = NOT_FOUND;
        end
      end
      ST_FIND: begin
        if (match_w[0]) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          status_nxt    = STAT_OK;
          found_nxt     = idx_ext[IDXO_W-1:0];
        end else if (idx_r == count_r - ONE_CNT) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          status_nxt    = STAT_OK;
          found_nxt     = NOT_FOUND;
        end else begin
          ctl.op  = CELL_SCAN;
          idx_nxt = idx_r + ONE_CNT;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    total_nxt = cnt_nxt_ext[IDXO_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lim_r    <= lim_nxt;
    idx_r    <= idx_nxt;
    status_r <= status_nxt;
    found_r  <= found_nxt;
    total_r  <= total_nxt;
  end

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic signed [VALUE_W-1:0] left_w;
      logic signed [VALUE_W-1:0] right_w;
      logic                      rmatch_w;

      if (gi == 0) begin : g_first
        assign left_w = '0;
      end else begin : g_mid
        assign left_w = entry_w[gi-1];
      end

      if (gi == CAPACITY - 1) begin : g_last
        assign right_w  = '0;
        assign rmatch_w = 1'b0;
      end else begin : g_inner
        assign right_w  = entry_w[gi+1];
        assign rmatch_w = match_w[gi+1];
      end

      olirs_cell #(
        .CNT_W (CW)
      ) u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .cell_idx    (CW'(gi)),
        .bound       (bound),
        .count       (count_r),
        .ctl         (ctl),
        .left_entry  (left_w),
        .right_entry (right_w),
        .head_entry  (entry_w[0]),
        .right_match (rmatch_w),
        .entry       (entry_w[gi]),
        .match       (match_w[gi])
      );
    end
  endgenerate

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_found_index = found_r;
  assign out_entry_total = total_r;

  `OLIRS_ASSERT_NOW(a_strobe_not_busy, out_valid, !busy, "result strobe while busy")
  `OLIRS_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CAP_CNT, "entry count above capacity")
  `OLIRS_ASSERT_NEXT(a_short_cmd_done, short_cmd, out_valid, "short command gave no result")
  `OLIRS_ASSERT_NOW(a_full_at_cap, out_valid && out_status == STAT_FULL, full, "bad full status")
  `OLIRS_ASSERT_NOW(a_rev_limit, state_r == ST_REV, lim_r >= TWO_CNT, "rotation limit below two")

endmodule

// File: tb/list_result_checker.sv
`timescale 1ns / 100ps

module list_result_checker #(
  parameter int CAPACITY = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  input  logic                                  busy,
  input  logic [olirs_pkg::CMD_W-1:0]           in_cmd,
  input  logic signed [olirs_pkg::VALUE_W-1:0]  in_value,
  input  logic [olirs_pkg::POS_W-1:0]           in_position,
  input  logic                                  out_valid,
  input  logic [olirs_pkg::STAT_W-1:0]          out_status,
  input  logic signed [olirs_pkg::IDXO_W-1:0]   out_found_index,
  input  logic [olirs_pkg::IDXO_W-1:0]          out_entry_total,
  output int                                    fail_count,
  output int                                    pending,
  output int                                    depth_now,
  output int                                    checked,
  output int                                    rejects,
  output int                                    hits
);
  import olirs_pkg::*;

  typedef struct {
    logic [STAT_W-1:0]         status;
    logic signed [IDXO_W-1:0]  found_index;
    logic [IDXO_W-1:0]         entry_total;
  } list_result_t;

  logic signed [VALUE_W-1:0] held [CAPACITY];
  int unsigned               held_count;
  list_result_t              expected_results [$];

  function automatic list_result_t apply_list_cmd(input logic [CMD_W-1:0] cmd,
                                                  input logic signed [VALUE_W-1:0] value,
                                                  input logic [POS_W-1:0] pos);
    list_result_t              r;
    logic signed [VALUE_W-1:0] swap_tmp;
    bit                        hit;
    r.status      = STAT_OK;
    r.found_index = NOT_FOUND;
    hit           = 1'b0;
    case (cmd)
      CMD_APPEND: begin
        if (held_count >= CAPACITY) begin
          r.status = STAT_FULL;
        end else begin
          held[held_count] = value;
          held_count++;
        end
      end
      CMD_INSERT_AT: begin
        if (held_count >= CAPACITY) begin
          r.status = STAT_FULL;
        end else if (pos > held_count) begin
          r.status = STAT_RANGE;
        end else begin
          for (int i = held_count; i > pos; i--) held[i] = held[i-1];
          held[pos] = value;
          held_count++;
        end
      end
      CMD_REMOVE_LAST: begin
        if (held_count == 0) r.status = STAT_EMPTY;
        else held_count--;
      end
      CMD_REMOVE_AT: begin
        if (held_count == 0) begin
          r.status = STAT_EMPTY;
        end else if (pos >= held_count) begin
          r.status = STAT_RANGE;
        end else begin
          for (int i = pos; i + 1 < held_count; i++) held[i] = held[i+1];
          held_count--;
        end
      end
      CMD_REVERSE: begin
        for (int i = 0; i < held_count / 2; i++) begin
          swap_tmp = held[i];
          held[i] = held[held_count-1-i];
          held[held_count-1-i] = swap_tmp;
        end
      end
      CMD_FIND: begin
        for (int i = 0; i < held_count; i++) begin
          if (!hit && held[i] == value) begin
            r.found_index = i[IDXO_W-1:0];
            hit = 1'b1;
          end
        end
      end
      default: ;
    endcase
    r.entry_total = held_count[IDXO_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    list_result_t exp_r;
    int           errs;
    errs = 0;
    if (!rst_n) begin
      held_count = 0;
      foreach (held[i]) held[i] = '0;
      expected_results.delete();
      fail_count <= 0;
      checked    <= 0;
      rejects    <= 0;
      hits       <= 0;
    end else begin
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          $error("result beat with nothing expected: status %0d found_index %0d entry_total %0d",
                 out_status, out_found_index, out_entry_total);
          errs++;
        end else begin
          exp_r = expected_results.pop_front();
          checked <= checked + 1;
          if (exp_r.status != STAT_OK) rejects <= rejects + 1;
          if (exp_r.found_index != $signed(NOT_FOUND)) hits <= hits + 1;
          if (out_status !== exp_r.status) begin
            $error("status mismatch: expected %0d, actual %0d", exp_r.status, out_status);
            errs++;
          end
          if (out_found_index !== exp_r.found_index) begin
            $error("found_index mismatch: expected %0d, actual %0d",
                   exp_r.found_index, out_found_index);
            errs++;
          end
          if (out_entry_total !== exp_r.entry_total) begin
            $error("entry_total mismatch: expected %0d, actual %0d",
                   exp_r.entry_total, out_entry_total);
            errs++;
          end
        end
      end
      if (start && !busy) expected_results.push_back(apply_list_cmd(in_cmd, in_value, in_position));
      fail_count <= fail_count + errs;
    end
    pending   <= expected_results.size();
    depth_now <= held_count;
  end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import olirs_pkg::*;

  localparam int CAPACITY = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_BEATS = 1600;
  localparam int QUIET_TAIL = 300;
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;
  localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        start = 1'b0;
  logic                        busy;
  logic [CMD_W-1:0]            in_cmd = '0;
  logic signed [VALUE_W-1:0]   in_value = '0;
  logic [POS_W-1:0]            in_position = '0;
  logic                        out_valid;
  logic [STAT_W-1:0]           out_status;
  logic signed [IDXO_W-1:0]    out_found_index;
  logic [IDXO_W-1:0]           out_entry_total;

  int fail_count;
  int pending;
  int depth_now;
  int checked;
  int rejects;
  int hits;
  int cycles = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  ordered_list_insert_remove_search #(.CAPACITY(CAPACITY)) uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cmd(in_cmd), .in_value(in_value), .in_position(in_position),
    .out_valid(out_valid), .out_status(out_status),
    .out_found_index(out_found_index), .out_entry_total(out_entry_total)
  );

  list_result_checker #(.CAPACITY(CAPACITY)) u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cmd(in_cmd), .in_value(in_value), .in_position(in_position),
    .out_valid(out_valid), .out_status(out_status),
    .out_found_index(out_found_index), .out_entry_total(out_entry_total),
    .fail_count(fail_count), .pending(pending), .depth_now(depth_now),
    .checked(checked), .rejects(rejects), .hits(hits)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // hold the beat until busy drops
  task automatic issue(input logic [CMD_W-1:0] cmd, input logic signed [VALUE_W-1:0] value,
                       input logic [POS_W-1:0] pos);
    in_cmd      <= cmd;
    in_value    <= value;
    in_position <= pos;
    start       <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  initial begin
    logic [CMD_W-1:0]          cmd;
    logic signed [VALUE_W-1:0] value;
    logic [POS_W-1:0]          pos;
    bit                        filling;
    int                        pick;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    issue(CMD_REMOVE_LAST, 0, 0);
    issue(CMD_REMOVE_AT, 0, 0);
    issue(CMD_REVERSE, 0, 0);
    issue(CMD_FIND, 0, 0);
    issue(CMD_SPARE_LO, VAL_MAX, 5'd31);
    issue(CMD_INSERT_AT, 7, 1);
    issue(CMD_INSERT_AT, VAL_MIN, 0);
    issue(CMD_APPEND, VAL_MAX, 0);
    issue(CMD_APPEND, 0, 0);
    issue(CMD_APPEND, -1, 0);
    issue(CMD_INSERT_AT, 32'sh5555_5555, 4);
    issue(CMD_INSERT_AT, 32'shAAAA_AAAA, 1);
    issue(CMD_FIND, -1, 0);
    issue(CMD_FIND, 12345, 0);
    issue(CMD_REVERSE, 0, 0);
    issue(CMD_FIND, VAL_MAX, 0);
    issue(CMD_FIND, VAL_MIN, 0);
    issue(CMD_REMOVE_AT, 0, 6);
    issue(CMD_REMOVE_AT, 0, 5'd31);
    issue(CMD_INSERT_AT, 1, 16);
    issue(CMD_REMOVE_AT, 0, 2);
    issue(CMD_REMOVE_AT, 0, 0);
    issue(CMD_REMOVE_LAST, 0, 0);
    issue(CMD_SPARE_HI, 0, 0);

    filling = 1'b1;
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (filling && depth_now >= CAPACITY && $urandom_range(0, 5) == 0) filling = 1'b0;
      if (!filling && depth_now == 0 && $urandom_range(0, 3) == 0) filling = 1'b1;

      pick = $urandom_range(0, 99);
      if (pick >= 98) cmd = $urandom_range(0, 1) ? CMD_SPARE_HI : CMD_SPARE_LO;
      else if (pick >= 82) cmd = CMD_FIND;
      else if (pick >= 74) cmd = CMD_REVERSE;
      else if (filling) begin
        if (pick < 30) cmd = CMD_APPEND;
        else if (pick < 60) cmd = CMD_INSERT_AT;
        else if (pick < 67) cmd = CMD_REMOVE_LAST;
        else cmd = CMD_REMOVE_AT;
      end else begin
        if (pick < 10) cmd = CMD_APPEND;
        else if (pick < 20) cmd = CMD_INSERT_AT;
        else if (pick < 45) cmd = CMD_REMOVE_LAST;
        else cmd = CMD_REMOVE_AT;
      end

      pick = $urandom_range(0, 9);
      if (pick < 5) value = $signed($urandom_range(0, 7)) - 2;
      else if (pick == 5) begin
        case ($urandom_range(0, 3))
          0: value = VAL_MIN;
          1: value = VAL_MAX;
          2: value = 0;
          default: value = -1;
        endcase
      end else value = $urandom;

      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        pos = POS_W'($urandom_range(0, 31));
      end else if (pick == 1) begin
        pos = POS_W'($urandom_range(0, CAPACITY));
      end else if (cmd == CMD_REMOVE_AT && depth_now > 0) begin
        pos = POS_W'($urandom_range(0, depth_now - 1));
      end else begin
        pos = POS_W'($urandom_range(0, depth_now));
      end

      issue(cmd, value, pos);

      if (n < RANDOM_BEATS - QUIET_TAIL && $urandom_range(0, 5) == 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
    start <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("%0d results checked: %0d rejected with a full, empty or range status, %0d finds hit",
             checked, rejects, hits);
    if (fail_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/olirs_pkg.sv
rtl/olirs_cell.sv
rtl/ordered_list_insert_remove_search.sv
tb/list_result_checker.sv
tb/tb_top.sv
